[rtl/core/qdre_pkg.sv]
// Shared types, constants and helpers of the quadrature decoder and rate estimator.
package qdre_pkg;

  localparam int unsigned RING_DEPTH_DEF = 16;

  localparam int unsigned CNT_W      = 32;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned CFG_W      = 24;
  localparam int unsigned MUL_W      = 20;
  localparam int unsigned NUM_W      = CNT_W + MUL_W;
  localparam int unsigned DIV_STEPS  = NUM_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [MUL_W-1:0] US_PER_S         = 20'd1000000;
  localparam logic [CFG_W-1:0] STOP_TIMEOUT_RST = 24'd50000;
  localparam logic [CFG_W-1:0] MIN_WINDOW_RST   = 24'd20000;
  localparam logic [CNT_W-1:0] RATE_MAX         = 32'h7FFF_FFFF;
  localparam logic [CNT_W-1:0] RATE_MIN         = 32'h8000_0000;

  typedef enum logic [1:0] {
    REG_CCW          = 2'd0,
    REG_STOP_TIMEOUT = 2'd1,
    REG_MIN_WINDOW   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_SAMPLE    = 2'd0,
    OP_LOAD_POS  = 2'd1,
    OP_CLEAR_ERR = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AGE,
    ST_WALK,
    ST_MUL,
    ST_DIV,
    ST_DONE_ZERO,
    ST_DONE_RATE
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]              opcode;
    logic                    pin_a;
    logic                    pin_b;
    logic [TIME_W-1:0]       time_us;
    logic signed [CNT_W-1:0] position_value;
  } in_item_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] position;
    logic signed [CNT_W-1:0] rate;
    logic                    sequence_error;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic rd_start;
    logic rd_next;
    logic win_capture;
    logic mul_load;
    logic div_step;
    logic out_load;
    logic rate_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic stale;
    logic tail_zero;
    logic tail_stop;
    logic div_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [1:0] next_phase(input logic [1:0] p);
    logic [1:0] r;
    case (p)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd3;
      2'd3:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/qdre_ctrl.sv]
// Sequencer: accept, staleness check, ring walk, multiply, divide, result hand-off.
module qdre_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qdre_pkg::dp_stat_t stat_i,
  output qdre_pkg::dp_cmd_t  cmd_o
);
  import qdre_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_AGE;
        end
      end
      ST_AGE: begin
        if (stat_i.stale) begin
          state_d = ST_DONE_ZERO;
        end else begin
          cmd_o.rd_start = 1'b1;
          state_d        = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.rd_next = 1'b1;
        if (stat_i.tail_zero) begin
          state_d = ST_DONE_ZERO;
        end else if (stat_i.tail_stop) begin
          cmd_o.win_capture = 1'b1;
          state_d           = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_DONE_RATE;
        end
      end
      ST_DONE_ZERO: begin
        if (stat_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.rate_zero = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_DONE_RATE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/qdre_datapath.sv]
// Datapath: decoder state, edge ring, window check, serial divider and output register.
module qdre_datapath #(
  parameter int unsigned RING_DEPTH = qdre_pkg::RING_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  qdre_pkg::in_item_t           in_data_i,
  input  logic                         ccw_i,
  input  logic [qdre_pkg::CFG_W-1:0]   stop_timeout_i,
  input  logic [qdre_pkg::CFG_W-1:0]   min_window_i,
  input  qdre_pkg::dp_cmd_t            cmd_i,
  output qdre_pkg::dp_stat_t           stat_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output qdre_pkg::out_item_t          out_data_o
);
  import qdre_pkg::*;

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

  // decoder state
  logic [1:0]        phase_q, phase_d;
  logic              primed_q, primed_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  offset_q, offset_d;
  logic              skip_q, skip_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  head_cnt_q, head_cnt_d;
  logic [TIME_W-1:0] head_time_q, head_time_d;
  logic [TIME_W-1:0] now_q;
  logic              push;

  // ring
  logic [CNT_W-1:0]      ring_cnt_q  [RING_DEPTH];
  logic [TIME_W-1:0]     ring_time_q [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld_q;
  logic [IDX_W-1:0]      head_inc, head_dec, ptr_dec;
  logic [IDX_W-1:0]      rd_ptr_q, rd_addr;
  logic                  rd_en;
  logic [CNT_W-1:0]      rd_cnt_q, tail_cnt;
  logic [TIME_W-1:0]     rd_time_q, tail_ts;
  logic                  rd_hit_q;

  // window and divider
  logic [TIME_W:0]      span;
  logic                 tail_eq, tail_newer, tail_wide, span_zero;
  logic [CNT_W-1:0]     diff_q, mag;
  logic [TIME_W-1:0]    span_q, age;
  logic                 neg_q;
  logic [NUM_W-1:0]     num_q;
  logic [TIME_W-1:0]    rem_q;
  logic [TIME_W:0]      rem_sh;
  logic                 ge;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  // output
  logic             out_valid_q;
  out_item_t        out_q;
  logic [CNT_W-1:0] pos_sum, pos_val, rate_val;
  logic             over_pos, over_neg;

  logic [1:0]       np;
  logic [CNT_W-1:0] target;

  assign head_inc = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? IDX_LAST : head_q - 1'b1;
  assign ptr_dec  = (rd_ptr_q == '0) ? IDX_LAST : rd_ptr_q - 1'b1;

  assign np     = {in_data_i.pin_a, in_data_i.pin_b};
  assign target = ccw_i ? (CNT_W'(0) - in_data_i.position_value) : in_data_i.position_value;

  always_comb begin
    phase_d     = phase_q;
    primed_d    = primed_q;
    count_d     = count_q;
    offset_d    = offset_q;
    skip_d      = skip_q;
    head_d      = head_q;
    head_cnt_d  = head_cnt_q;
    head_time_d = head_time_q;
    push        = 1'b0;
    if (cmd_i.load) begin
      case (in_data_i.opcode)
        OP_SAMPLE: begin
          if (!primed_q) begin
            phase_d  = np;
            primed_d = 1'b1;
          end else if (np != phase_q) begin
            if (np == next_phase(phase_q)) begin
              count_d = count_q + 1'b1;
              push    = 1'b1;
            end else if (phase_q == next_phase(np)) begin
              count_d = count_q - 1'b1;
              push    = 1'b1;
            end else begin
              skip_d = 1'b1;
            end
            phase_d = np;
          end
        end
        OP_LOAD_POS:  offset_d = target - count_q;
        OP_CLEAR_ERR: skip_d = 1'b0;
        default: ;
      endcase
      if (push) begin
        head_d      = head_inc;
        head_cnt_d  = count_d;
        head_time_d = in_data_i.time_us;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      primed_q    <= 1'b0;
      count_q     <= '0;
      offset_q    <= '0;
      skip_q      <= 1'b0;
      head_q      <= '0;
      head_cnt_q  <= '0;
      head_time_q <= '0;
      ring_vld_q  <= '0;
    end else begin
      phase_q     <= phase_d;
      primed_q    <= primed_d;
      count_q     <= count_d;
      offset_q    <= offset_d;
      skip_q      <= skip_d;
      head_q      <= head_d;
      head_cnt_q  <= head_cnt_d;
      head_time_q <= head_time_d;
      if (push) begin
        ring_vld_q[head_inc] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q <= in_data_i.time_us;
    end
    if (push) begin
      ring_cnt_q[head_inc]  <= count_d;
      ring_time_q[head_inc] <= in_data_i.time_us;
    end
  end

  // ring read port, one entry per cycle walking back from the head
  assign rd_en   = cmd_i.rd_start | cmd_i.rd_next;
  assign rd_addr = cmd_i.rd_start ? head_dec : ptr_dec;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_ptr_q  <= rd_addr;
      rd_cnt_q  <= ring_cnt_q[rd_addr];
      rd_time_q <= ring_time_q[rd_addr];
      rd_hit_q  <= ring_vld_q[rd_addr];
    end
  end

  assign tail_cnt = rd_hit_q ? rd_cnt_q : '0;
  assign tail_ts  = rd_hit_q ? rd_time_q : '0;

  assign age        = now_q - head_time_q;
  assign span       = {1'b0, head_time_q} - {1'b0, tail_ts};
  assign tail_eq    = (tail_cnt == head_cnt_q);
  assign tail_newer = span[TIME_W];
  assign tail_wide  = (span[TIME_W-1:0] >= TIME_W'(min_window_i));
  assign span_zero  = (span[TIME_W-1:0] == '0);

  assign stat_o.stale     = (age > TIME_W'(stop_timeout_i));
  assign stat_o.tail_zero = tail_eq | tail_newer | (tail_wide & span_zero);
  assign stat_o.tail_stop = ~tail_eq & ~tail_newer & tail_wide & ~span_zero;
  assign stat_o.div_last  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat_o.out_free  = ~out_valid_q | ~out_stall_i;

  // restoring divider, one quotient bit per cycle
  assign mag    = diff_q[CNT_W-1] ? (CNT_W'(0) - diff_q) : diff_q;
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, span_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_capture) begin
      diff_q <= head_cnt_q - tail_cnt;
      span_q <= span[TIME_W-1:0];
    end
    if (cmd_i.mul_load) begin
      num_q     <= NUM_W'(mag) * NUM_W'(US_PER_S);
      rem_q     <= '0;
      div_cnt_q <= '0;
      neg_q     <= diff_q[CNT_W-1] ^ ccw_i;
    end else if (cmd_i.div_step) begin
      num_q     <= {num_q[NUM_W-2:0], ge};
      rem_q     <= ge ? TIME_W'(rem_sh - {1'b0, span_q}) : rem_sh[TIME_W-1:0];
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // result formatting
  assign pos_sum  = count_q + offset_q;
  assign pos_val  = ccw_i ? (CNT_W'(0) - pos_sum) : pos_sum;
  assign over_pos = |num_q[NUM_W-1:CNT_W-1];
  assign over_neg = (|num_q[NUM_W-1:CNT_W]) | (num_q[CNT_W-1] & (|num_q[CNT_W-2:0]));

  always_comb begin
    if (cmd_i.rate_zero) begin
      rate_val = '0;
    end else if (neg_q) begin
      rate_val = over_neg ? RATE_MIN : (CNT_W'(0) - num_q[CNT_W-1:0]);
    end else begin
      rate_val = over_pos ? RATE_MAX : num_q[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.position       <= pos_val;
      out_q.rate           <= rate_val;
      out_q.sequence_error <= skip_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/core/quadrature_decoder_rate_estimator.sv]
// Top level: quadrature decoder with ring-based rate estimate and APB register block.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+---------------------------
//  in      | sink      | in_valid_i / in_stall_o     | in_data_i  (in_item_t)
//  out     | source    | out_valid_o / out_stall_i   | out_data_o (out_item_t)
//  cfg     | APB slave | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One transaction at a time: accept, age check, ring walk (one ring read per cycle, back
// from the entry before the head), multiply, serial division, then load of the result.
// A stale sample ends in a zero rate with no walk; a walk ends in a zero rate or goes on
// to the division. It reads at most RING_DEPTH entries, since the last entry walked
// is the head itself and always ends in zero.
// The output register holds a result while out_stall_i is high; the next transaction
// is taken meanwhile and waits in its last cycle for the register to free up.
// Reset is asynchronous; the ring reads as zero until written, no clearing pass.
module quadrature_decoder_rate_estimator #(
  parameter int unsigned RING_DEPTH = qdre_pkg::RING_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  qdre_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output qdre_pkg::out_item_t                out_data_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [qdre_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [qdre_pkg::DATA_W-1:0]        pwdata,
  output logic [qdre_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import qdre_pkg::*;

  logic             ccw_q;
  logic [CFG_W-1:0] stop_timeout_q;
  logic [CFG_W-1:0] min_window_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccw_q          <= 1'b0;
      stop_timeout_q <= STOP_TIMEOUT_RST;
      min_window_q   <= MIN_WINDOW_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CCW:          ccw_q          <= pwdata[0];
        REG_STOP_TIMEOUT: stop_timeout_q <= pwdata[CFG_W-1:0];
        REG_MIN_WINDOW:   min_window_q   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CCW:          prdata = DATA_W'(ccw_q);
      REG_STOP_TIMEOUT: prdata = DATA_W'(stop_timeout_q);
      REG_MIN_WINDOW:   prdata = DATA_W'(min_window_q);
      default:          prdata = '0;
    endcase
  end

  qdre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  qdre_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_data_i      (in_data_i),
    .ccw_i          (ccw_q),
    .stop_timeout_i (stop_timeout_q),
    .min_window_i   (min_window_q),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

[verif/quadrature_decoder_rate_estimator_test.sv]
// Testbench for the quadrature decoder and rate estimator: directed table, random walks, scoreboard.
`timescale 1ns / 100ps

module quadrature_decoder_rate_estimator_test;
  import qdre_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 80;
  localparam int HIST_DEPTH = RING_DEPTH_DEF;
  localparam int RANDOM_PER_PHASE = 75;
  localparam int NUM_PHASES = 6;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_CCW = {REG_CCW, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_STOP = {REG_STOP_TIMEOUT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW = {REG_MIN_WINDOW, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = 4'd12;

  localparam logic [1:0] GRAY_UP [4] = '{2'd1, 2'd3, 2'd0, 2'd2};
  localparam logic [1:0] GRAY_DOWN [4] = '{2'd2, 2'd0, 2'd3, 2'd1};

  typedef struct packed {
    logic [1:0]  op;
    logic        pin_a;
    logic        pin_b;
    logic [47:0] t;
    logic [31:0] pv;
    logic        typed;
    logic [31:0] pos;
    logic [31:0] rate;
    logic        err;
  } stim_row_t;

  typedef struct packed {
    logic      valid;
    out_item_t val;
  } typed_t;

  localparam stim_row_t STIM_TABLE [16] = '{
    '{OP_SAMPLE,    1'b0, 1'b0, 48'd0,          32'd0,         1'b1, 32'd0, 32'd0, 1'b0},
    '{OP_SAMPLE,    1'b0, 1'b1, 48'd1000,       32'd0,         1'b1, 32'd1, 32'd0, 1'b0},
    '{OP_SAMPLE,    1'b1, 1'b1, 48'd30000,      32'd0,         1'b0, 32'd0, 32'd0, 1'b0},
    '{OP_SAMPLE,    1'b1, 1'b1, 48'd30010,      32'hFFFFFFFF,  1'b0, 32'd0, 32'd0, 1'b0},
    '{OP_SAMPLE,    1'b0, 1'b1, 48'd60000,      32'd0,         1'b0, 32'd0, 32'd0, 1'b0},
    '{OP_SAMPLE,    1'b1, 1'b0, 48'd60000,      32'd0,         1'b0, 32'd0, 32'd0, 1'b0},
    '{OP_CLEAR_ERR, 1'b1, 1'b1, 48'd60000,      32'h12345678,  1'b0, 32'd0, 32'd0, 1'b0},
    '{OP_LOAD_POS,  1'b0, 1'b0, 48'd60000,      32'h7FFFFFFF,  1'b1, 32'h7FFFFFFF,
      -32'sd33, 1'b0},
    '{OP_SAMPLE,    1'b0, 1'b0, 48'd60000,      32'd0,         1'b0, 32'd0, 32'd0, 1'b0},
    '{OP_LOAD_POS,  1'b1, 1'b1, 48'd60000,      32'h80000000,  1'b0, 32'd0, 32'd0, 1'b0},
    '{OP_SPARE,     1'b1, 1'b1, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h80000000,
      32'd0, 1'b0},
    '{OP_SAMPLE,    1'b0, 1'b1, 48'hFFFFFFFFFFFF, 32'd0,        1'b0, 32'd0, 32'd0, 1'b0},
    '{OP_SAMPLE,    1'b1, 1'b1, 48'd5,          32'd0,         1'b0, 32'd0, 32'd0, 1'b0},
    '{OP_SAMPLE,    1'b1, 1'b1, 48'd100000,     32'd0,         1'b0, 32'd0, 32'd0, 1'b0},
    '{OP_SAMPLE,    1'b0, 1'b0, 48'd100000,     32'd0,         1'b0, 32'd0, 32'd0, 1'b0},
    '{OP_LOAD_POS,  1'b0, 1'b0, 48'd100000,     32'd0,         1'b0, 32'd0, 32'd0, 1'b0}
  };

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  quadrature_decoder_rate_estimator DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // predictor state
  logic             cfg_ccw = 1'b0;
  logic [23:0]      cfg_stop = STOP_TIMEOUT_RST;
  logic [23:0]      cfg_window = MIN_WINDOW_RST;
  logic [1:0]       pred_phase = 2'd0;
  logic             pred_armed = 1'b0;
  logic [31:0]      pred_count = '0;
  logic [31:0]      pred_offset = '0;
  logic             pred_skip = 1'b0;
  logic [3:0]       hist_head = '0;
  logic [31:0]      hist_count [HIST_DEPTH] = '{default: '0};
  logic [47:0]      hist_time [HIST_DEPTH] = '{default: '0};

  out_item_t expected_readings [$];
  typed_t    typed_pending [$];
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int items_in = 0;
  int results_seen = 0;
  int cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_item_t track_position_rate(input in_item_t it);
    logic [1:0]  pins;
    logic [31:0] pos;
    logic [31:0] target;
    logic [31:0] hc;
    logic [31:0] tc;
    logic [47:0] ht;
    logic [47:0] tt;
    logic [3:0]  tail;
    longint      rate;
    bit          walking;
    int          x;
    out_item_t   res;
    pins = {it.pin_a, it.pin_b};
    case (it.opcode)
      OP_SAMPLE: begin
        if (!pred_armed) begin
          pred_phase = pins;
          pred_armed = 1'b1;
        end else if (pins != pred_phase) begin
          if (pins == GRAY_UP[pred_phase] || pred_phase == GRAY_UP[pins]) begin
            pred_count = (pins == GRAY_UP[pred_phase]) ? pred_count + 32'd1
                                                       : pred_count - 32'd1;
            hist_head = hist_head + 4'd1;
            hist_count[hist_head] = pred_count;
            hist_time[hist_head] = it.time_us;
          end else begin
            pred_skip = 1'b1;
          end
          pred_phase = pins;
        end
      end
      OP_LOAD_POS: begin
        target = cfg_ccw ? 32'd0 - it.position_value : it.position_value;
        pred_offset = target - pred_count;
      end
      OP_CLEAR_ERR: pred_skip = 1'b0;
      default: ;
    endcase
    pos = pred_count + pred_offset;
    if (cfg_ccw) pos = 32'd0 - pos;

    rate = 0;
    hc = hist_count[hist_head];
    ht = hist_time[hist_head];
    walking = (it.time_us - ht) <= {24'd0, cfg_stop};
    for (x = 1; x <= HIST_DEPTH && walking; x++) begin
      tail = hist_head - x[3:0];
      tc = hist_count[tail];
      tt = hist_time[tail];
      if (tc == hc || tt > ht) begin
        walking = 1'b0;
      end else if (ht - tt >= {24'd0, cfg_window}) begin
        walking = 1'b0;
        if (ht != tt) rate = (longint'($signed(hc - tc)) * 1000000) / longint'(ht - tt);
      end
    end
    if (cfg_ccw) rate = -rate;
    if (rate > 64'sd2147483647) rate = 64'sd2147483647;
    if (rate < -64'sd2147483648) rate = -64'sd2147483648;

    res.position = pos;
    res.rate = rate[31:0];
    res.sequence_error = pred_skip;
    return res;
  endfunction

  // scoreboard: input accept first, then output check, in one block
  always @(posedge clk_i) begin : scoreboard
    out_item_t want;
    out_item_t pred;
    typed_t    tv;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pred = track_position_rate(in_data_i);
      tv = typed_pending.pop_front();
      expected_readings.push_back(tv.valid ? tv.val : pred);
      items_in++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_readings.size() == 0) begin
        $display("%0t unexpected result: position %0d rate %0d error %0b", $time,
                 out_data_o.position, out_data_o.rate, out_data_o.sequence_error);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (want.position !== out_data_o.position) begin
          $display("%0t position: expected %0d, got %0d", $time, want.position,
                   out_data_o.position);
          mismatches++;
        end
        if (want.rate !== out_data_o.rate) begin
          $display("%0t rate: expected %0d, got %0d", $time, want.rate, out_data_o.rate);
          mismatches++;
        end
        if (want.sequence_error !== out_data_o.sequence_error) begin
          $display("%0t sequence_error: expected %0b, got %0b", $time,
                   want.sequence_error, out_data_o.sequence_error);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d results outstanding", $time, expected_readings.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic drive_item(input in_item_t it, input logic typed, input out_item_t tval);
    typed_t tv;
    tv.valid = typed;
    tv.val = tval;
    typed_pending.push_back(tv);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_CCW:    cfg_ccw = data[0];
      ADDR_STOP:   cfg_stop = data[23:0];
      ADDR_WINDOW: cfg_window = data[23:0];
      default: ;
    endcase
  endtask

  initial begin
    in_item_t    it;
    stim_row_t   row;
    out_item_t   tval;
    int          ph;
    int          roll;
    int          pick;
    logic [1:0]  gen_pins;
    bit          gen_dir;
    logic [47:0] gen_now;
    logic [47:0] step_max;
    logic [31:0] junk;
    logic        ccw_set;
    logic [23:0] stop_set;
    logic [23:0] win_set;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (STIM_TABLE[i]) begin
      row = STIM_TABLE[i];
      it.opcode = row.op;
      it.pin_a = row.pin_a;
      it.pin_b = row.pin_b;
      it.time_us = row.t;
      it.position_value = row.pv;
      tval.position = row.pos;
      tval.rate = row.rate;
      tval.sequence_error = row.err;
      drive_item(it, row.typed, tval);
    end

    gen_dir = 1'b1;
    gen_now = STIM_TABLE[15].t;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      if (ph > 0) begin
        case (ph)
          1: begin ccw_set = 1'b1; stop_set = 24'hFFFFFF; win_set = 24'd0; end
          2: begin ccw_set = 1'b0; stop_set = 24'd0; win_set = 24'hFFFFFF; end
          3: begin ccw_set = 1'b1; stop_set = 24'd3000; win_set = 24'd800; end
          4: begin
            ccw_set = 1'b0;
            stop_set = 24'($urandom_range(1, 200000));
            win_set = 24'($urandom_range(0, 40000));
          end
          default: begin ccw_set = 1'b1; stop_set = STOP_TIMEOUT_RST; win_set = MIN_WINDOW_RST; end
        endcase
        junk = $urandom;
        write_reg(ADDR_CCW, {junk[31:1], ccw_set});
        junk = $urandom;
        write_reg(ADDR_STOP, {junk[31:24], stop_set});
        junk = $urandom;
        write_reg(ADDR_WINDOW, {junk[31:24], win_set});
        if (ph == 4) write_reg(ADDR_SPARE, $urandom);
      end
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 87; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 87; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      gen_pins = pred_phase;
      step_max = (cfg_window == 24'd0) ? 48'd400 : {24'd0, cfg_window} / 4 + 48'd1;

      repeat (RANDOM_PER_PHASE) begin
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        if (pick < 3) begin
          gen_now = gen_now + {24'd0, cfg_stop} + 48'd1 + 48'($urandom_range(0, 999));
        end else if (pick < 5) begin
          gen_now = 48'({$urandom, $urandom});
        end else begin
          gen_now = gen_now + 48'($urandom_range(0, 32'(step_max)));
        end
        it.pin_a = 1'($urandom);
        it.pin_b = 1'($urandom);
        it.position_value = $urandom;
        it.time_us = gen_now;
        if (roll < 78) begin
          it.opcode = OP_SAMPLE;
          if ($urandom_range(99) < 8) gen_dir = ~gen_dir;
          pick = $urandom_range(99);
          if (pick < 75) gen_pins = gen_dir ? GRAY_UP[gen_pins] : GRAY_DOWN[gen_pins];
          else if (pick < 83) gen_pins = gen_dir ? GRAY_DOWN[gen_pins] : GRAY_UP[gen_pins];
          else if (pick >= 93) gen_pins = ~gen_pins;
          {it.pin_a, it.pin_b} = gen_pins;
        end else if (roll < 86) begin
          it.opcode = OP_LOAD_POS;
          pick = $urandom_range(3);
          if (pick == 0) it.position_value = 32'sh7FFFFFFF;
          else if (pick == 1) it.position_value = 32'sh80000000;
        end else if (roll < 93) begin
          it.opcode = OP_CLEAR_ERR;
        end else begin
          it.opcode = OP_SPARE;
        end
        drive_item(it, 1'b0, '0);
      end
    end

    settle();
    $display("Sent %0d transactions (directed table, then gray-code walks with skips,",
             items_in);
    $display("loads and stale gaps) under %0d register settings; checked %0d results.",
             NUM_PHASES, results_seen);
    if (mismatches == 0 && typed_pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
